### rtl/uart_line_receiver_double_buffer_macros.svh
// Assertion macros shared by the line receiver RTL.
// Needs a clock named clk and an active-high reset named rst in the using module.
`ifndef UART_LINE_RECEIVER_DOUBLE_BUFFER_MACROS_SVH
`define UART_LINE_RECEIVER_DOUBLE_BUFFER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LRDB_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line receiver assertion failed");
// next-cycle implication
`define LRDB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line receiver assertion failed");
`else
`define LRDB_ASSERT_IMPL(label, ante, cons)
`define LRDB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### rtl/lrdb_pkg.sv
// Shared types, constants and helpers of the double-buffered line receiver.
// No dependencies; used by every module in rtl/.
package lrdb_pkg;

  localparam int LINE_BYTES = 64;
  localparam int DEPTH      = 2 * LINE_BYTES;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int FILL_W     = $clog2(LINE_BYTES + 1);
  localparam int IDX_W      = 6;
  localparam int LEN_W      = 7;
  localparam int CMP_W      = FILL_W + IDX_W;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [7:0] NEWLINE = 8'h0A;

  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_TAKE = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_TIMEOUT_EN = 1'b0;
  localparam logic REG_GAP_LIMIT  = 1'b1;

  typedef struct packed {
    logic [1:0]       func;
    logic [7:0]       rx_byte;
    logic [31:0]      now_ms;
    logic [IDX_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    logic             line_ready;
    logic [LEN_W-1:0] line_length;
    logic             line_bank;
    logic             overflow;
    logic [7:0]       read_data;
  } result_t;

  typedef struct packed {
    logic        timeout_enable;
    logic [15:0] gap_limit;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             line_ready;
    logic [LEN_W-1:0] line_length;
    logic             line_bank;
    logic             overflow;
    logic             rd_hit;
  } status_t;

  function automatic logic [LEN_W-1:0] len_field(input logic [FILL_W-1:0] f);
    logic [FILL_W+LEN_W-1:0] w;
    w = (FILL_W + LEN_W)'(f);
    return w[LEN_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic bank,
                                                 input logic [CMP_W-1:0] pos);
    logic [CMP_W:0] a;
    a = (CMP_W + 1)'(pos) + (bank ? (CMP_W + 1)'(LINE_BYTES) : '0);
    return a[ADDR_W-1:0];
  endfunction

endpackage

### rtl/uart_line_receiver_double_buffer.sv
// Double-buffered line receiver: receive, take and read items over valid/stall channels.
// Uses lrdb_pkg, lrdb_regs, lrdb_ctrl and lrdb_store.
//
// The block collects received bytes into two ping-pong line banks kept in one 128x8
// synchronous RAM. A newline completes the line and flips banks; a full bank or a missed
// inter-byte deadline (against now_ms, set through the APB registers) raises overflow.
// Every item gives exactly one result. One item is accepted per clock while input is
// not stalled. The item's transfer edge also issues the RAM read and loads the read
// stage; the output register is loaded from the read stage once it is free, which
// raises result_valid. The RAM is written and read at most once per cycle, and since a
// read of an entry always comes at a later edge than the write to it, it always sees
// the new byte. The line store has no reset or clearing pass; the block takes items
// right after reset. Input is stalled only when both the RAM stage and the output
// register hold results that the consumer has not yet taken.
`include "uart_line_receiver_double_buffer_macros.svh"
module uart_line_receiver_double_buffer (
  input  logic                            clk,
  input  logic                            rst,
  // item channel
  input  logic                            item_valid,
  output logic                            item_stall,
  input  lrdb_pkg::item_t                 item,
  // result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output lrdb_pkg::result_t               result,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrdb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lrdb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lrdb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  lrdb_pkg::cfg_t     cfg;
  lrdb_pkg::mem_req_t mem_req;
  lrdb_pkg::status_t  status;
  lrdb_pkg::status_t  s1_status;
  logic               s1_valid;
  logic [7:0]         rdata;
  logic               accept, out_move, s1_move;

  // Output register frees when empty or when its transfer completes.
  assign out_move   = !result_valid || !result_stall;
  assign s1_move    = s1_valid && out_move;
  assign item_stall = s1_valid && !out_move;
  assign accept     = item_valid && !item_stall;

  lrdb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lrdb_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .item    (item),
    .cfg     (cfg),
    .mem_req (mem_req),
    .status  (status)
  );

  // Read data only changes on an accepted read, so it holds while stage 1 waits.
  lrdb_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // Stage 1: wait out the RAM read latency.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status;
    end
  end

  // Output register: hold under stall, advance from stage 1 otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_move) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.line_ready  <= s1_status.line_ready;
      result.line_length <= s1_status.line_length;
      result.line_bank   <= s1_status.line_bank;
      result.overflow    <= s1_status.overflow;
      result.read_data   <= s1_status.rd_hit ? rdata : 8'd0;
    end
  end

  `LRDB_ASSERT_NEXT(a_s1_hold, s1_valid && !out_move, s1_valid && $stable(s1_status))
  `LRDB_ASSERT_NEXT(a_rdata_hold, s1_valid && !out_move && s1_status.rd_hit, $stable(rdata))
  `LRDB_ASSERT_NEXT(a_out_fed, !result_valid && !s1_valid, !result_valid)

endmodule

### rtl/lrdb_store.sv
// Line store: both ping-pong banks in one synchronous RAM, one write and one read port.
// Uses lrdb_pkg for depth and request type.
module lrdb_store (
  input  logic              clk,
  input  lrdb_pkg::mem_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0] mem [lrdb_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

### rtl/lrdb_regs.sv
// APB configuration registers: timeout enable and timeout length.
// Uses lrdb_pkg for register codes and the config struct.
module lrdb_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrdb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [lrdb_pkg::APB_DATA_W-1:0] pwdata,
  output logic [lrdb_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output lrdb_pkg::cfg_t                  cfg
);

  logic reg_sel;
  logic wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[lrdb_pkg::APB_ADDR_W-1];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_enable <= 1'b1;
      cfg.gap_limit      <= 16'd100;
    end else if (wr) begin
      case (reg_sel)
        lrdb_pkg::REG_TIMEOUT_EN: cfg.timeout_enable <= pwdata[0];
        lrdb_pkg::REG_GAP_LIMIT:  cfg.gap_limit      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      lrdb_pkg::REG_TIMEOUT_EN: prdata = {31'd0, cfg.timeout_enable};
      lrdb_pkg::REG_GAP_LIMIT:  prdata = {16'd0, cfg.gap_limit};
      default:                  prdata = '0;
    endcase
  end

endmodule

### rtl/lrdb_ctrl.sv
// Line control: fill counts, bank flip, ready/overflow flags and the inter-byte deadline.
// Uses lrdb_pkg; issues write and read requests to lrdb_store.
`include "uart_line_receiver_double_buffer_macros.svh"
module lrdb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  lrdb_pkg::item_t     item,
  input  lrdb_pkg::cfg_t      cfg,
  output lrdb_pkg::mem_req_t  mem_req,
  output lrdb_pkg::status_t   status
);

  logic [lrdb_pkg::FILL_W-1:0] fill [2];
  logic [lrdb_pkg::FILL_W-1:0] fill_next [2];
  logic                        active, active_next;
  logic                        ready, ready_next;
  logic [lrdb_pkg::FILL_W-1:0] rlen, rlen_next;
  logic                        rbank, rbank_next;
  logic                        ovf, ovf_next;
  logic [31:0]                 deadline, deadline_next;

  logic [31:0]                 lag, arm, dl_byte;
  logic                        late, fits, is_nl, in_range, take_ovf;
  logic [lrdb_pkg::FILL_W-1:0] fill_base;
  logic [lrdb_pkg::CMP_W-1:0]  idx_c;

  assign lag     = item.now_ms - deadline;
  assign late    = cfg.timeout_enable && (deadline != '0) && !lag[31];
  assign arm     = item.now_ms + 32'(cfg.gap_limit);
  assign dl_byte = !cfg.timeout_enable ? '0 : ((arm == '0) ? 32'd1 : arm);

  assign fill_base = late ? '0 : fill[active];
  assign fits      = fill_base < lrdb_pkg::FILL_W'(lrdb_pkg::LINE_BYTES);
  assign is_nl     = item.rx_byte == lrdb_pkg::NEWLINE;

  assign idx_c    = lrdb_pkg::CMP_W'(item.read_index);
  assign in_range = (idx_c < lrdb_pkg::CMP_W'(rlen)) &&
                    (idx_c < lrdb_pkg::CMP_W'(lrdb_pkg::LINE_BYTES));

  always_comb begin
    fill_next     = fill;
    active_next   = active;
    ready_next    = ready;
    rlen_next     = rlen;
    rbank_next    = rbank;
    ovf_next      = ovf;
    deadline_next = deadline;
    take_ovf      = 1'b0;
    if (accept) begin
      case (item.func)
        lrdb_pkg::FUNC_BYTE: begin
          deadline_next = dl_byte;
          ovf_next      = ovf || late;
          if (fits) begin
            fill_next[active] = fill_base + 1'b1;
            if (is_nl) begin
              ready_next         = 1'b1;
              rlen_next          = fill_base + 1'b1;
              rbank_next         = active;
              active_next        = ~active;
              fill_next[~active] = '0;
              deadline_next      = '0;
            end
          end else begin
            // full buffer: drop the byte and restart the line
            ovf_next          = 1'b1;
            fill_next[active] = '0;
            deadline_next     = '0;
          end
        end
        lrdb_pkg::FUNC_TAKE: begin
          take_ovf   = ovf;
          ovf_next   = 1'b0;
          ready_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill[0]  <= '0;
      fill[1]  <= '0;
      active   <= 1'b0;
      ready    <= 1'b0;
      rlen     <= '0;
      rbank    <= 1'b0;
      ovf      <= 1'b0;
      deadline <= '0;
    end else begin
      fill     <= fill_next;
      active   <= active_next;
      ready    <= ready_next;
      rlen     <= rlen_next;
      rbank    <= rbank_next;
      ovf      <= ovf_next;
      deadline <= deadline_next;
    end
  end

  always_comb begin
    mem_req.we    = accept && (item.func == lrdb_pkg::FUNC_BYTE) && fits;
    mem_req.waddr = lrdb_pkg::mem_addr(active, lrdb_pkg::CMP_W'(fill_base));
    mem_req.wdata = item.rx_byte;
    mem_req.re    = accept && (item.func == lrdb_pkg::FUNC_READ) && in_range;
    mem_req.raddr = lrdb_pkg::mem_addr(rbank, idx_c);
  end

  always_comb begin
    status.line_ready  = ready_next;
    status.line_length = take_ovf ? '0 : lrdb_pkg::len_field(rlen_next);
    status.line_bank   = rbank_next;
    status.overflow    = ovf_next;
    status.rd_hit      = (item.func == lrdb_pkg::FUNC_READ) && in_range;
  end

  `LRDB_ASSERT_IMPL(a_fill_bound, 1'b1,
    (fill[0] <= lrdb_pkg::FILL_W'(lrdb_pkg::LINE_BYTES)) &&
    (fill[1] <= lrdb_pkg::FILL_W'(lrdb_pkg::LINE_BYTES)))
  `LRDB_ASSERT_IMPL(a_port_exclusive, mem_req.we, !mem_req.re)
  `LRDB_ASSERT_NEXT(a_newline_flips, mem_req.we && is_nl, (active != $past(active)) && ready)

endmodule
